### rtl/mcpid_pkg.sv
// ----------------------------------------------------------------------------
// Multi-channel position PID: shared package
// Types, constants and register codes used across the controller's files.
// ----------------------------------------------------------------------------
package mcpid_pkg;

	// Number of motor channels that carry state.
	localparam int CHANNELS   = 4;
	localparam int CHAN_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Field widths fixed by the interface.
	localparam int CHAN_W    = 2;
	localparam int VAL_W     = 16;
	localparam int GAIN_W    = 16;
	localparam int INTEG_W   = 32;
	localparam int ERR_W     = VAL_W + 1;
	localparam int DIFF_W    = ERR_W + 1;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	// Product and sum widths.
	localparam int PROD_P_W = GAIN_W + ERR_W;
	localparam int PROD_I_W = GAIN_W + INTEG_W;
	localparam int PROD_D_W = GAIN_W + DIFF_W;
	localparam int SUM_W    = PROD_I_W + 2;
	localparam int RND_W    = SUM_W - 8 + 2;

	// Offset added to the control value to form the PWM value.
	localparam logic [VAL_W-1:0] PWM_OFFSET = 16'd500;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P         = 3'd0,
		REG_GAIN_I         = 3'd1,
		REG_GAIN_D         = 3'd2,
		REG_INTEGRAL_UPPER = 3'd3,
		REG_INTEGRAL_LOWER = 3'd4,
		REG_OUTPUT_UPPER   = 3'd5,
		REG_OUTPUT_LOWER   = 3'd6
	} cfg_reg_e;

	// Command codes of a step item.
	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef struct packed {
		logic                     cmd;
		logic [CHAN_W-1:0]        channel;
		logic signed [VAL_W-1:0]  target;
		logic signed [VAL_W-1:0]  measure;
	} step_t;

	typedef struct packed {
		logic [CHAN_W-1:0]        channel_out;
		logic signed [VAL_W-1:0]  control;
		logic [VAL_W-1:0]         pwm_value;
	} result_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0]  gain_p;
		logic signed [GAIN_W-1:0]  gain_i;
		logic signed [GAIN_W-1:0]  gain_d;
		logic signed [INTEG_W-1:0] integral_upper;
		logic signed [INTEG_W-1:0] integral_lower;
		logic signed [VAL_W-1:0]   output_upper;
		logic signed [VAL_W-1:0]   output_lower;
	} cfg_t;

	// Terms of one item after the state update.
	typedef struct packed {
		logic                      zero;
		logic [CHAN_W-1:0]         channel;
		logic signed [ERR_W-1:0]   err;
		logic signed [INTEG_W-1:0] integ;
		logic signed [DIFF_W-1:0]  diff;
	} term_t;

	// Weighted terms of one item.
	typedef struct packed {
		logic                       zero;
		logic [CHAN_W-1:0]          channel;
		logic signed [PROD_P_W-1:0] prod_p;
		logic signed [PROD_I_W-1:0] prod_i;
		logic signed [PROD_D_W-1:0] prod_d;
	} prod_t;

endpackage

### rtl/mcpid_cfg.sv
// ----------------------------------------------------------------------------
// Multi-channel position PID: configuration registers
// Holds the gains and clamp limits shared by all channels.
// ----------------------------------------------------------------------------
module mcpid_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [mcpid_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcpid_pkg::CFG_DAT_W-1:0] cfg_data,
	output mcpid_pkg::cfg_t               cfg
);
	import mcpid_pkg::*;

	cfg_t cfg_q;

	// A write to an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_e'(cfg_index))
				REG_GAIN_P:         cfg_q.gain_p         <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:         cfg_q.gain_i         <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:         cfg_q.gain_d         <= cfg_data[GAIN_W-1:0];
				REG_INTEGRAL_UPPER: cfg_q.integral_upper <= cfg_data[INTEG_W-1:0];
				REG_INTEGRAL_LOWER: cfg_q.integral_lower <= cfg_data[INTEG_W-1:0];
				REG_OUTPUT_UPPER:   cfg_q.output_upper   <= cfg_data[VAL_W-1:0];
				REG_OUTPUT_LOWER:   cfg_q.output_lower   <= cfg_data[VAL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/mcpid_state.sv
// ----------------------------------------------------------------------------
// Multi-channel position PID: channel state
// Computes error, clamped integral and error difference for one item and
// updates the channel's stored integral and last error when the item moves on.
// ----------------------------------------------------------------------------
module mcpid_state (
	input  logic             clk,
	input  logic             arst_n,
	input  mcpid_pkg::step_t step,
	input  logic             update,
	input  mcpid_pkg::cfg_t  cfg,
	output mcpid_pkg::term_t term
);
	import mcpid_pkg::*;

	logic signed [INTEG_W-1:0] integ_q [CHANNELS];
	logic signed [ERR_W-1:0]   last_q  [CHANNELS];

	logic [CHAN_IDX_W-1:0]     idx;
	logic                      in_range;
	logic signed [INTEG_W-1:0] cur_integ;
	logic signed [ERR_W-1:0]   cur_last;
	logic signed [ERR_W-1:0]   err;
	logic signed [INTEG_W:0]   integ_sum;
	logic signed [INTEG_W:0]   integ_clamped;
	logic signed [DIFF_W-1:0]  diff;

	assign idx      = CHAN_IDX_W'(step.channel);
	assign in_range = (32'(step.channel) < CHANNELS);

	// Read the channel's state; a channel without state reads as zero.
	always_comb begin
		cur_integ = '0;
		cur_last  = '0;
		if (in_range) begin
			cur_integ = integ_q[idx];
			cur_last  = last_q[idx];
		end
	end

	// Error, integral with anti-windup clamp, and derivative difference.
	// The upper clamp goes first so that the lower limit wins when crossed.
	always_comb begin
		err = ERR_W'(step.target) - ERR_W'(step.measure);
		integ_sum = (INTEG_W+1)'(cur_integ) + (INTEG_W+1)'(err);
		integ_clamped = integ_sum;
		if (integ_clamped > (INTEG_W+1)'(cfg.integral_upper)) begin
			integ_clamped = (INTEG_W+1)'(cfg.integral_upper);
		end
		if (integ_clamped < (INTEG_W+1)'(cfg.integral_lower)) begin
			integ_clamped = (INTEG_W+1)'(cfg.integral_lower);
		end
		diff = DIFF_W'(err) - DIFF_W'(cur_last);
	end

	always_comb begin
		term.zero    = (step.cmd == CMD_CLEAR) || !in_range;
		term.channel = step.channel;
		term.err     = err;
		term.integ   = integ_clamped[INTEG_W-1:0];
		term.diff    = diff;
	end

	// Read-modify-write of the channel state as the item leaves this stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				integ_q[i] <= '0;
				last_q[i]  <= '0;
			end
		end else if (update && in_range) begin
			if (step.cmd == CMD_CLEAR) begin
				integ_q[idx] <= '0;
				last_q[idx]  <= '0;
			end else begin
				integ_q[idx] <= integ_clamped[INTEG_W-1:0];
				last_q[idx]  <= err;
			end
		end
	end

endmodule

### rtl/mcpid_mul.sv
// ----------------------------------------------------------------------------
// Multi-channel position PID: gain multipliers
// Weights the error, integral and error difference by their Q8.8 gains.
// ----------------------------------------------------------------------------
module mcpid_mul (
	input  mcpid_pkg::term_t term,
	input  mcpid_pkg::cfg_t  cfg,
	output mcpid_pkg::prod_t prod
);
	import mcpid_pkg::*;

	// Three independent signed multiplies, side by side.
	always_comb begin
		prod.zero    = term.zero;
		prod.channel = term.channel;
		prod.prod_p  = PROD_P_W'(cfg.gain_p) * PROD_P_W'(term.err);
		prod.prod_i  = PROD_I_W'(cfg.gain_i) * PROD_I_W'(term.integ);
		prod.prod_d  = PROD_D_W'(cfg.gain_d) * PROD_D_W'(term.diff);
	end

endmodule

### rtl/mcpid_out.sv
// ----------------------------------------------------------------------------
// Multi-channel position PID: output stage
// Sums the weighted terms, rounds from Q8.8, clamps and forms the PWM value.
// ----------------------------------------------------------------------------
module mcpid_out (
	input  mcpid_pkg::prod_t   prod,
	input  mcpid_pkg::cfg_t    cfg,
	output mcpid_pkg::result_t result
);
	import mcpid_pkg::*;

	logic signed [SUM_W-1:0] sum;
	logic [SUM_W-1:0]        mag;
	logic [SUM_W:0]          mag_rnd;
	logic [RND_W-1:0]        rnd_mag;
	logic signed [RND_W-1:0] rnd;
	logic signed [RND_W-1:0] clamped;
	logic signed [VAL_W-1:0] control;

	// Sum and round to nearest, halves away from zero.
	always_comb begin
		sum = SUM_W'(prod.prod_p) + SUM_W'(prod.prod_i) + SUM_W'(prod.prod_d);
		mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
		mag_rnd = (SUM_W+1)'(mag) + (SUM_W+1)'(128);
		rnd_mag = RND_W'(mag_rnd >> 8);
		rnd = sum[SUM_W-1] ? -$signed(rnd_mag) : $signed(rnd_mag);
	end

	// Output clamp; the lower limit wins when the limits are crossed.
	always_comb begin
		clamped = rnd;
		if (clamped > RND_W'(cfg.output_upper)) begin
			clamped = RND_W'(cfg.output_upper);
		end
		if (clamped < RND_W'(cfg.output_lower)) begin
			clamped = RND_W'(cfg.output_lower);
		end
		control = prod.zero ? '0 : clamped[VAL_W-1:0];
	end

	always_comb begin
		result.channel_out = prod.channel;
		result.control     = control;
		result.pwm_value   = VAL_W'(control) + PWM_OFFSET;
	end

endmodule

### rtl/multi_channel_position_pid.sv
// ----------------------------------------------------------------------------
// Multi-channel position PID controller
// Positional PID with anti-windup clamp for several motor channels.
// ----------------------------------------------------------------------------
// The controller takes one item per clock cycle while step_stall is low and
// gives one result for each, in order. The items pass an input register, a
// state stage where the channel's integral and last error are read and
// rewritten in the same cycle, a multiplier stage and an output register;
// because the state update finishes in one stage, items for the same channel
// may follow one another in consecutive cycles. Each stage moves on whenever
// the stage after it is empty or moving, so a result held by stall does not
// stop items already behind it from closing up. Configuration writes are
// always ready and should be made while no item is in flight.
// ----------------------------------------------------------------------------
module multi_channel_position_pid (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step_valid,
	output logic                            step_stall,
	input  mcpid_pkg::step_t                step,
	output logic                            result_valid,
	input  logic                            result_stall,
	output mcpid_pkg::result_t              result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mcpid_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcpid_pkg::CFG_DAT_W-1:0] cfg_data
);
	import mcpid_pkg::*;

	cfg_t    cfg;
	step_t   step_s1;
	term_t   term;
	term_t   term_s2;
	prod_t   prod;
	prod_t   prod_s3;
	result_t res;
	result_t result_q;

	logic valid_s1, valid_s2, valid_s3, result_valid_q;
	logic rdy_out, rdy_s3, rdy_s2, rdy_s1;

	// Each stage can take an item when empty or when its item moves on.
	assign rdy_out = !result_valid_q || !result_stall;
	assign rdy_s3  = !valid_s3 || rdy_out;
	assign rdy_s2  = !valid_s2 || rdy_s3;
	assign rdy_s1  = !valid_s1 || rdy_s2;

	assign step_stall = !rdy_s1;
	assign cfg_ready  = 1'b1;

	mcpid_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mcpid_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step_s1),
		.update (valid_s1 && rdy_s2),
		.cfg    (cfg),
		.term   (term)
	);

	mcpid_mul u_mul (
		.term (term_s2),
		.cfg  (cfg),
		.prod (prod)
	);

	mcpid_out u_out (
		.prod   (prod_s3),
		.cfg    (cfg),
		.result (res)
	);

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= step_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_out) begin
				result_valid_q <= valid_s3;
			end
		end
	end

	// Payload registers load only when their stage takes a new item.
	always_ff @(posedge clk) begin
		if (rdy_s1 && step_valid) begin
			step_s1 <= step;
		end
		if (rdy_s2 && valid_s1) begin
			term_s2 <= term;
		end
		if (rdy_s3 && valid_s2) begin
			prod_s3 <= prod;
		end
		if (rdy_out && valid_s3) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### rtl/mcpid_checker.sv
// ----------------------------------------------------------------------------
// Multi-channel position PID: port checker
// Watches the controller's ports and flags results that break its rules.
// ----------------------------------------------------------------------------
module mcpid_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               step_valid,
	input logic               step_stall,
	input logic               result_valid,
	input logic               result_stall,
	input mcpid_pkg::result_t result
);
	import mcpid_pkg::*;

	// The PWM value always follows the control value by the fixed offset.
	a_pwm_offset: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.pwm_value == VAL_W'(VAL_W'(result.control) + PWM_OFFSET)))
		else $error("pwm_value does not match control plus offset");

	// An accepted item has a result on show within the pipeline latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(step_valid && !step_stall) |-> ##4 result_valid)
		else $error("no result on show after an accepted item");

	// A stalled result stays on show.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> result_valid)
		else $error("result withdrawn while stalled");

	// A stalled result does not change.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> $stable(result))
		else $error("result changed while stalled");

endmodule

bind multi_channel_position_pid mcpid_checker u_mcpid_checker (.*);

### verif/tb_multi_channel_position_pid.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the multi-channel position PID controller
// Drives step and clear items with random idling on both channels, predicts
// every result from a local model of the channel state and the shared
// registers, and checks each result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_multi_channel_position_pid;
	import mcpid_pkg::*;

	// Predicts the controller's results and checks them in order.
	class pid_scoreboard;
		logic signed [GAIN_W-1:0]  kp, ki, kd;
		logic signed [INTEG_W-1:0] integ_hi, integ_lo;
		logic signed [VAL_W-1:0]   out_hi, out_lo;
		logic signed [INTEG_W-1:0] integral_acc [CHANNELS];
		logic signed [ERR_W-1:0]   last_err [CHANNELS];
		result_t                   expected_q [$];
		int                        mismatches, results_seen, steps_seen, clears_seen;

		function new();
			kp = '0; ki = '0; kd = '0;
			integ_hi = '0; integ_lo = '0; out_hi = '0; out_lo = '0;
			foreach (integral_acc[i]) begin
				integral_acc[i] = '0;
				last_err[i]     = '0;
			end
			mismatches = 0; results_seen = 0; steps_seen = 0; clears_seen = 0;
		endfunction

		// Keeps the local copy of the registers in line with each write.
		function void set_reg(cfg_reg_e idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				REG_GAIN_P:         kp       = data[GAIN_W-1:0];
				REG_GAIN_I:         ki       = data[GAIN_W-1:0];
				REG_GAIN_D:         kd       = data[GAIN_W-1:0];
				REG_INTEGRAL_UPPER: integ_hi = data;
				REG_INTEGRAL_LOWER: integ_lo = data;
				REG_OUTPUT_UPPER:   out_hi   = data[VAL_W-1:0];
				REG_OUTPUT_LOWER:   out_lo   = data[VAL_W-1:0];
				default: ;
			endcase
		endfunction

		// Works out the control value of an accepted item and updates the state.
		function void note_step(step_t item);
			longint  err, integ, total, ctrl;
			result_t exp_res;
			ctrl = 0;
			if (item.channel < CHANNELS) begin
				if (item.cmd == CMD_CLEAR) begin
					integral_acc[item.channel] = '0;
					last_err[item.channel]     = '0;
					clears_seen++;
				end else begin
					err   = longint'($signed(item.target)) - longint'($signed(item.measure));
					integ = longint'(integral_acc[item.channel]) + err;
					if (integ > longint'(integ_hi)) integ = integ_hi;
					if (integ < longint'(integ_lo)) integ = integ_lo;
					total = longint'(kp) * err + longint'(ki) * integ
						+ longint'(kd) * (err - longint'(last_err[item.channel]));
					// Halves round away from zero.
					if (total >= 0)
						ctrl = (total + 128) >>> 8;
					else
						ctrl = -((-total + 128) >>> 8);
					if (ctrl > longint'(out_hi)) ctrl = out_hi;
					if (ctrl < longint'(out_lo)) ctrl = out_lo;
					integral_acc[item.channel] = integ[INTEG_W-1:0];
					last_err[item.channel]     = err[ERR_W-1:0];
					steps_seen++;
				end
			end
			exp_res.channel_out = item.channel;
			exp_res.control     = ctrl[VAL_W-1:0];
			exp_res.pwm_value   = PWM_OFFSET + ctrl[VAL_W-1:0];
			expected_q.push_back(exp_res);
		endfunction

		task report_mismatch(string msg);
			$display("Mismatch at %0t ns: %s", $time, msg);
			mismatches++;
		endtask

		// Compares an accepted result with the oldest expectation.
		task check_result(result_t got);
			result_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				report_mismatch("result arrived with nothing expected");
			end else begin
				want = expected_q.pop_front();
				if (got.channel_out !== want.channel_out)
					report_mismatch($sformatf("channel_out %0d, expected %0d",
						got.channel_out, want.channel_out));
				if (got.control !== want.control)
					report_mismatch($sformatf("control %0d on channel %0d, expected %0d",
						$signed(got.control), want.channel_out, $signed(want.control)));
				if (got.pwm_value !== want.pwm_value)
					report_mismatch($sformatf("pwm_value %0d on channel %0d, expected %0d",
						got.pwm_value, want.channel_out, want.pwm_value));
			end
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 step_valid;
	logic                 step_stall;
	step_t                step_item;
	logic                 result_valid;
	logic                 result_stall;
	result_t              result_item;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	pid_scoreboard sb;
	bit            no_idle;
	int            settings_used;

	multi_channel_position_pid dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_valid   (step_valid),
		.step_stall   (step_stall),
		.step         (step_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the length of the run.
	initial begin
		#6_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Mostly short idle stretches, with the occasional long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Both channels are sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (step_valid && !step_stall) sb.note_step(step_item);
			if (result_valid && !result_stall) sb.check_result(result_item);
		end
	end

	// Result stall, changed only at the falling edge.
	initial begin
		int stall_left;
		stall_left   = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result_stall = 1'b1;
				stall_left--;
			end else begin
				result_stall = 1'b0;
				if (!no_idle && $urandom_range(0, 3) == 0) stall_left = idle_len();
			end
		end
	end

	// Offers one item after a random gap and waits until it is taken.
	task automatic send_step(input logic cmd, input int ch, input int tgt, input int meas);
		step_t item;
		int    gap;
		item.cmd     = cmd;
		item.channel = ch[CHAN_W-1:0];
		item.target  = tgt[VAL_W-1:0];
		item.measure = meas[VAL_W-1:0];
		gap = no_idle ? 0 : idle_len();
		@(negedge clk);
		if (gap > 0) begin
			step_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		step_valid = 1'b1;
		step_item  = item;
		do @(posedge clk); while (step_stall);
	endtask

	// Holds the sender back until every expected result has come.
	task automatic wait_results_done();
		@(negedge clk);
		step_valid = 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DAT_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Writes every register; only called while the controller is idle.
	task automatic load_config(input logic [15:0] kp, input logic [15:0] ki,
		input logic [15:0] kd, input logic [31:0] ih, input logic [31:0] il,
		input logic [15:0] oh, input logic [15:0] ol);
		write_reg(REG_GAIN_P, {{16{kp[15]}}, kp});
		write_reg(REG_GAIN_I, {{16{ki[15]}}, ki});
		write_reg(REG_GAIN_D, {{16{kd[15]}}, kd});
		write_reg(REG_INTEGRAL_UPPER, ih);
		write_reg(REG_INTEGRAL_LOWER, il);
		write_reg(REG_OUTPUT_UPPER, {{16{oh[15]}}, oh});
		write_reg(REG_OUTPUT_LOWER, {{16{ol[15]}}, ol});
		settings_used++;
	endtask

	function automatic logic [15:0] pick_gain();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'h8000;
		if (r == 1) return 16'h7fff;
		if (r < 6) return 16'($urandom_range(0, 2048) - 1024);
		return 16'($urandom);
	endfunction

	// A random setting: mostly ordered limits, sometimes extremes or crossed.
	task automatic load_random_config();
		logic [31:0] ih, il;
		logic [15:0] oh, ol;
		int          r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			ih = 32'h7fff_ffff; il = 32'h8000_0000;
		end else if (r == 1) begin
			ih = $urandom; il = $urandom;
		end else begin
			ih = $urandom_range(0, 300000);
			il = -$urandom_range(0, 300000);
		end
		r = $urandom_range(0, 9);
		if (r == 0) begin
			oh = 16'h7fff; ol = 16'h8000;
		end else if (r == 1) begin
			oh = 16'($urandom); ol = 16'($urandom);
		end else begin
			oh = 16'($urandom_range(0, 32767));
			ol = 16'(-$urandom_range(0, 32768));
		end
		load_config(pick_gain(), pick_gain(), pick_gain(), ih, il, oh, ol);
	endtask

	// Reset, directed items, then random phases under changing settings.
	initial begin
		int tgt, meas;
		sb            = new();
		settings_used = 0;
		no_idle       = 1'b0;
		arst_n        = 1'b0;
		step_valid    = 1'b0;
		step_item     = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_GAIN_P;
		cfg_data      = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// Rounding of halves in both directions and the extremes of the error.
		load_config(16'sd128, 16'sd0, 16'sd0, 32'h7fff_ffff, 32'h8000_0000,
			16'h7fff, 16'h8000);
		send_step(CMD_STEP, 0, 1, 0);
		send_step(CMD_STEP, 1, 0, 1);
		send_step(CMD_STEP, 2, 3, 0);
		send_step(CMD_STEP, 3, -3, 0);
		send_step(CMD_STEP, 0, 32767, -32768);
		send_step(CMD_STEP, 1, -32768, 32767);
		send_step(CMD_CLEAR, 0, $urandom, $urandom);
		wait_results_done();

		// Crossed integral limits pin the integral at its top; extreme gains.
		load_config(16'h8000, 16'h7fff, 16'h8000, 32'h8000_0000, 32'h7fff_ffff,
			16'h7fff, 16'h8000);
		send_step(CMD_STEP, 2, 32767, -32768);
		send_step(CMD_STEP, 2, -32768, 32767);
		send_step(CMD_STEP, 3, 0, 0);
		send_step(CMD_CLEAR, 2, $urandom, $urandom);
		send_step(CMD_STEP, 2, 0, 0);
		wait_results_done();

		// Crossed output limits: the lower limit wins.
		load_config(16'sd256, 16'sd256, 16'sd256, 32'sd1000, -32'sd1000,
			-16'sd100, 16'sd100);
		send_step(CMD_STEP, 1, 5, 0);
		send_step(CMD_STEP, 1, -5000, 0);
		send_step(CMD_CLEAR, 3, $urandom, $urandom);
		send_step(CMD_STEP, 3, -32768, -32768);
		wait_results_done();

		// Successive items on one channel under moderate gains.
		load_config(16'sd300, 16'sd40, -16'sd500, 32'sd2000, -32'sd2000,
			16'sd1000, -16'sd1000);
		send_step(CMD_STEP, 0, 100, 50);
		send_step(CMD_STEP, 0, 100, 60);
		send_step(CMD_STEP, 0, 100, 90);
		send_step(CMD_STEP, 0, 100, 130);
		wait_results_done();

		// Random phases; one in four runs with no idling on either side.
		for (int ph = 0; ph < 8; ph++) begin
			no_idle = (ph % 4 == 3);
			load_random_config();
			for (int n = 0; n < 100; n++) begin
				tgt = $signed(16'($urandom));
				if ($urandom_range(0, 1) == 0)
					meas = $signed(16'($urandom));
				else
					meas = tgt + $urandom_range(0, 200) - 100;
				if ($urandom_range(0, 11) == 0)
					send_step(CMD_CLEAR, $urandom_range(0, 3), tgt, meas);
				else
					send_step(CMD_STEP, $urandom_range(0, 3), tgt, meas);
				if (n == 50) wait_results_done();
			end
			wait_results_done();
		end
		no_idle = 1'b0;

		$display("Covered %0d step items and %0d clear items over %0d register settings.",
			sb.steps_seen, sb.clears_seen, settings_used);
		$display("%0d results checked, %0d mismatches.", sb.results_seen, sb.mismatches);
		if (sb.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
